FILE: hdl/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// shared types and codes for the length-prefixed deframer
// ----------------------------------------------------------------------------
package lpd_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int BYTE_BITS   = 8;
    localparam int KIND_BITS   = 2;

    localparam logic [LENGTH_BITS-1:0] MAX_BODY_LENGTH_RESET = 16'd1024;

    // result kinds
    localparam logic [KIND_BITS-1:0] KIND_BYTE  = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_EMPTY = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_ERROR = 2'd2;

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [BYTE_BITS-1:0]   body_byte;
        logic                   last_of_message;
        logic [LENGTH_BITS-1:0] message_length;
    } result_t;

endpackage

FILE: hdl/length_prefixed_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_deframer
// splits a byte stream into messages with a 16-bit big-endian length header
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                 payload
// -------   ---------  ------------------------  -----------------------------
// data      in         data_valid / data_stall   data_byte
// result    out        result_valid / result_stall
//                                                kind, body_byte,
//                                                last_of_message, message_length
// config    in         cfg_we (no wait)          cfg_wdata (max_body_length)
//
// one request per cycle sustained while data_stall is low; each result is
// registered in the output register, or first in the skid register while the output stalls
// header parse, length compare and byte count all settle in the accept cycle
// a skid register behind the output register takes one more result while
// result_stall is high; data_stall is simply the skid register being full
// reset clears the parser, the halt state and both result valid flags, and
// loads the maximum body length with 1024
// after a length error the block keeps taking requests but drops them
//
module length_prefixed_deframer
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             data_valid,
    output logic                             data_stall,
    input  logic [lpd_pkg::BYTE_BITS-1:0]    data_byte,

    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [lpd_pkg::KIND_BITS-1:0]    kind,
    output logic [lpd_pkg::BYTE_BITS-1:0]    body_byte,
    output logic                             last_of_message,
    output logic [lpd_pkg::LENGTH_BITS-1:0]  message_length,

    input  logic                             cfg_we,
    input  logic [lpd_pkg::LENGTH_BITS-1:0]  cfg_wdata
);

    // parser phases
    localparam logic [1:0] PH_HIGH = 2'd0;
    localparam logic [1:0] PH_LOW  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;
    localparam logic [1:0] PH_HALT = 2'd3;

    logic [1:0]                      phase_reg, phase_next;
    logic [lpd_pkg::BYTE_BITS-1:0]   header_high_reg, header_high_next;
    logic [lpd_pkg::LENGTH_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [lpd_pkg::LENGTH_BITS-1:0] declared_length_reg, declared_length_next;
    logic [lpd_pkg::LENGTH_BITS-1:0] max_body_length_reg;

    // output register and skid register
    logic             out_valid_reg, out_valid_next;
    lpd_pkg::result_t out_reg, out_next;
    logic             skid_valid_reg, skid_valid_next;
    lpd_pkg::result_t skid_reg, skid_next;

    logic                            accept;
    logic                            res_fire;
    lpd_pkg::result_t                res;
    logic [lpd_pkg::LENGTH_BITS-1:0] header_len;
    logic                            out_free;

    assign data_stall = skid_valid_reg;
    assign accept     = data_valid && !skid_valid_reg;
    assign header_len = {header_high_reg, data_byte};

    // ------------------------------------------------------------------
    // parser: one byte per request, at most one result
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next           = phase_reg;
        header_high_next     = header_high_reg;
        bytes_left_next      = bytes_left_reg;
        declared_length_next = declared_length_reg;
        res_fire             = 1'b0;
        res.kind             = lpd_pkg::KIND_BYTE;
        res.body_byte        = '0;
        res.last_of_message  = 1'b0;
        res.message_length   = '0;

        if (accept)
        begin
            case (phase_reg)
                PH_HIGH:
                begin
                    header_high_next = data_byte;
                    phase_next       = PH_LOW;
                end
                PH_LOW:
                begin
                    declared_length_next = header_len;
                    if (header_len > max_body_length_reg)
                    begin
                        // oversized header: report and halt until reset
                        phase_next         = PH_HALT;
                        bytes_left_next    = '0;
                        res_fire           = 1'b1;
                        res.kind           = lpd_pkg::KIND_ERROR;
                        res.message_length = header_len;
                    end
                    else if (header_len == '0)
                    begin
                        phase_next          = PH_HIGH;
                        bytes_left_next     = '0;
                        res_fire            = 1'b1;
                        res.kind            = lpd_pkg::KIND_EMPTY;
                        res.last_of_message = 1'b1;
                    end
                    else
                    begin
                        bytes_left_next = header_len;
                        phase_next      = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    res_fire            = 1'b1;
                    res.kind            = lpd_pkg::KIND_BYTE;
                    res.body_byte       = data_byte;
                    res.message_length  = declared_length_reg;
                    res.last_of_message = (bytes_left_reg <= 16'd1);
                    if (bytes_left_reg <= 16'd1)
                    begin
                        bytes_left_next = '0;
                        phase_next      = PH_HIGH;
                    end
                    else
                    begin
                        bytes_left_next = bytes_left_reg - 1'b1;
                    end
                end
                default:
                begin
                    // halted: drop the byte
                    phase_next = PH_HALT;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // output register with skid
    // ------------------------------------------------------------------
    always_comb
    begin
        out_free        = !out_valid_reg || !result_stall;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;

        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                // no request accepted while the skid is full
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_fire;
                if (res_fire)
                begin
                    out_next = res;
                end
            end
        end
        else if (res_fire)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_HIGH;
            header_high_reg     <= '0;
            bytes_left_reg      <= '0;
            declared_length_reg <= '0;
            max_body_length_reg <= lpd_pkg::MAX_BODY_LENGTH_RESET;
            out_valid_reg       <= 1'b0;
            skid_valid_reg      <= 1'b0;
        end
        else
        begin
            phase_reg           <= phase_next;
            header_high_reg     <= header_high_next;
            bytes_left_reg      <= bytes_left_next;
            declared_length_reg <= declared_length_next;
            out_valid_reg       <= out_valid_next;
            skid_valid_reg      <= skid_valid_next;
            if (cfg_we)
            begin
                max_body_length_reg <= cfg_wdata;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result_valid    = out_valid_reg;
    assign kind            = out_reg.kind;
    assign body_byte       = out_reg.body_byte;
    assign last_of_message = out_reg.last_of_message;
    assign message_length  = out_reg.message_length;

endmodule
